### design/mrp_pkg.sv
package mrp_pkg;

	// Layout register indexes on the configuration channel.
	typedef enum logic [2:0] {
		REG_REPORT_ID   = 3'd0,
		REG_BTN_OFFSET  = 3'd1,
		REG_BTN_BYTES   = 3'd2,
		REG_AXIS_OFFSET = 3'd3,
		REG_AXIS_BYTES  = 3'd4,
		REG_WHEEL_OFFSET = 3'd5,
		REG_WHEEL_SIGNED = 3'd6
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	// A wheel offset of this value means the report carries no wheel.
	localparam logic [7:0] NO_WHEEL       = 8'd255;
	// The byte position saturates here.
	localparam logic [7:0] POS_MAX        = 8'd255;
	// Mask for an unsigned 7-bit wheel.
	localparam logic [7:0] WHEEL_LOW_MASK = 8'h7F;

	// Layout registers.
	typedef struct packed {
		logic [7:0] report_id_expected;
		logic [7:0] button_field_offset;
		logic [1:0] button_field_bytes;
		logic [7:0] axis_field_offset;
		logic [1:0] axis_bytes_each;
		logic [7:0] wheel_field_offset;
		logic       wheel_is_signed;
	} layout_t;

endpackage

### design/mrp_if.sv
// Byte stream of a raw input report.
interface mrp_report_if;
	logic        valid;
	logic        ready;
	logic [7:0]  report_byte;
	logic        end_of_report;
	logic [63:0] time_stamp;

	modport source (output valid, report_byte, end_of_report, time_stamp, input ready);
	modport sink (input valid, report_byte, end_of_report, time_stamp, output ready);
endinterface

// One parsed result per report.
interface mrp_result_if;
	logic               valid;
	logic               ready;
	logic               report_ok;
	logic [15:0]        button_bits;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [7:0]  wheel_delta;
	logic [63:0]        motion_time;

	modport source (output valid, report_ok, button_bits, delta_x, delta_y, wheel_delta,
		motion_time, input ready);
	modport sink (input valid, report_ok, button_bits, delta_x, delta_y, wheel_delta,
		motion_time, output ready);
endinterface

// Layout register writes.
interface mrp_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] reg_index;
	logic [7:0] write_data;

	modport source (output valid, reg_index, write_data, input ready);
	modport sink (input valid, reg_index, write_data, output ready);
endinterface

### design/mouse_report_parser.sv
// Mouse report parser. Report bytes stream in on the report channel, one per
// transfer, and a byte may follow in every cycle. Each byte is registered, then
// placed into the button, axis and wheel fields by the layout registers in one
// pass of logic; the byte that carries end_of_report passes the input register and
// then, once the result channel is free, produces one result in the output register.
// Throughput is one byte per cycle, set by the single input register and the
// result register; the report channel stalls only while a finished result waits
// and a further last byte is ready behind it. Layout registers are written on
// the cfg channel, which is always ready, and should change only between reports.
module mouse_report_parser (
	input logic clk,
	input logic arst_n,
	mrp_report_if.sink report,
	mrp_result_if.source result,
	mrp_cfg_if.sink cfg
);
	import mrp_pkg::*;

	layout_t layout_q;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eor_s1;
	logic [63:0] ts_s1;

	// Per-report state.
	logic [7:0]  pos_q;
	logic [15:0] button_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  wheel_q;
	logic        wheel_present_q;
	logic        id_matched_q;

	// Result register.
	logic               res_valid_q;
	logic               res_ok_q;
	logic [15:0]        res_button_q;
	logic [15:0]        res_x_q;
	logic [15:0]        res_y_q;
	logic [7:0]         res_wheel_q;
	logic [63:0]        res_time_q;

	logic        out_free;
	logic        adv_s1;
	logic [1:0]  btn_len;
	logic [1:0]  axis_len;
	logic [7:0]  btn_rel;
	logic [7:0]  axis_rel;
	logic        id_next;
	logic [15:0] button_next;
	logic [15:0] x_next;
	logic [15:0] y_next;
	logic [7:0]  wheel_next;
	logic        wheel_present_next;
	logic [7:0]  pos_next;
	logic [9:0]  report_len;
	logic [9:0]  need_axis;
	logic [9:0]  need_btn;
	logic        ok;
	logic [7:0]  wheel_val;
	logic [15:0] x_val;
	logic [15:0] y_val;

	// Layout register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q.report_id_expected  <= 8'd0;
			layout_q.button_field_offset <= 8'd0;
			layout_q.button_field_bytes  <= 2'd1;
			layout_q.axis_field_offset   <= 8'd1;
			layout_q.axis_bytes_each     <= 2'd1;
			layout_q.wheel_field_offset  <= NO_WHEEL;
			layout_q.wheel_is_signed     <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_REPORT_ID:    layout_q.report_id_expected  <= cfg.write_data;
				REG_BTN_OFFSET:   layout_q.button_field_offset <= cfg.write_data;
				REG_BTN_BYTES:    layout_q.button_field_bytes  <= cfg.write_data[1:0];
				REG_AXIS_OFFSET:  layout_q.axis_field_offset   <= cfg.write_data;
				REG_AXIS_BYTES:   layout_q.axis_bytes_each     <= cfg.write_data[1:0];
				REG_WHEEL_OFFSET: layout_q.wheel_field_offset  <= cfg.write_data;
				REG_WHEEL_SIGNED: layout_q.wheel_is_signed     <= cfg.write_data[0];
				default: ;
			endcase
		end
	end

	// Flow control: a last byte moves on only when the result register is free.
	assign out_free     = !res_valid_q || result.ready;
	assign adv_s1       = valid_s1 && (!eor_s1 || out_free);
	assign report.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (report.ready) begin
			valid_s1 <= report.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report.valid && report.ready) begin
			byte_s1 <= report.report_byte;
			eor_s1  <= report.end_of_report;
			ts_s1   <= report.time_stamp;
		end
	end

	// Field placement for the byte in the input stage.
	always_comb begin
		btn_len  = (layout_q.button_field_bytes == 2'd0) ? 2'd0 :
			(layout_q.button_field_bytes == 2'd1) ? 2'd1 : 2'd2;
		axis_len = (layout_q.axis_bytes_each == 2'd1) ? 2'd1 : 2'd2;
		btn_rel  = pos_q - layout_q.button_field_offset;
		axis_rel = pos_q - layout_q.axis_field_offset;

		id_next = id_matched_q;
		if (pos_q == 8'd0) begin
			id_next = (layout_q.report_id_expected == 8'd0) ||
				(byte_s1 == layout_q.report_id_expected);
		end

		button_next = button_q;
		if (pos_q >= layout_q.button_field_offset && btn_rel < {6'd0, btn_len}) begin
			if (btn_rel[0]) begin
				button_next = {byte_s1, button_q[7:0]};
			end else begin
				button_next = {button_q[15:8], byte_s1};
			end
		end

		x_next = x_q;
		y_next = y_q;
		if (pos_q >= layout_q.axis_field_offset) begin
			if (axis_rel < {6'd0, axis_len}) begin
				if (axis_rel == 8'd0) begin
					x_next = {x_q[15:8], byte_s1};
				end else begin
					x_next = {byte_s1, x_q[7:0]};
				end
			end else if (axis_rel < {5'd0, axis_len, 1'b0}) begin
				if (axis_rel == {6'd0, axis_len}) begin
					y_next = {y_q[15:8], byte_s1};
				end else begin
					y_next = {byte_s1, y_q[7:0]};
				end
			end
		end

		wheel_next         = wheel_q;
		wheel_present_next = wheel_present_q;
		if (layout_q.wheel_field_offset != NO_WHEEL && pos_q == layout_q.wheel_field_offset) begin
			wheel_next         = byte_s1;
			wheel_present_next = 1'b1;
		end

		pos_next = (pos_q < POS_MAX) ? pos_q + 8'd1 : pos_q;
	end

	// Result fields for a last byte.
	always_comb begin
		report_len = {2'd0, pos_q} + 10'd1;
		need_axis  = {2'd0, layout_q.axis_field_offset} + {7'd0, axis_len, 1'b0};
		need_btn   = {2'd0, layout_q.button_field_offset} + {8'd0, btn_len};
		ok = id_next && (report_len >= need_axis) && (report_len >= need_btn);

		wheel_val = 8'd0;
		if (layout_q.wheel_field_offset != NO_WHEEL && wheel_present_next) begin
			wheel_val = layout_q.wheel_is_signed ? wheel_next : (wheel_next & WHEEL_LOW_MASK);
		end

		x_val = (axis_len == 2'd1) ? {{8{x_next[7]}}, x_next[7:0]} : x_next;
		y_val = (axis_len == 2'd1) ? {{8{y_next[7]}}, y_next[7:0]} : y_next;
	end

	// Report state; cleared after each last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= 8'd0;
			button_q        <= 16'd0;
			x_q             <= 16'd0;
			y_q             <= 16'd0;
			wheel_q         <= 8'd0;
			wheel_present_q <= 1'b0;
			id_matched_q    <= 1'b0;
		end else if (adv_s1) begin
			if (eor_s1) begin
				pos_q           <= 8'd0;
				button_q        <= 16'd0;
				x_q             <= 16'd0;
				y_q             <= 16'd0;
				wheel_q         <= 8'd0;
				wheel_present_q <= 1'b0;
				id_matched_q    <= 1'b0;
			end else begin
				pos_q           <= pos_next;
				button_q        <= button_next;
				x_q             <= x_next;
				y_q             <= y_next;
				wheel_q         <= wheel_next;
				wheel_present_q <= wheel_present_next;
				id_matched_q    <= id_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && eor_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eor_s1) begin
			res_ok_q     <= ok;
			res_button_q <= ok ? button_next : 16'd0;
			res_x_q      <= ok ? x_val : 16'd0;
			res_y_q      <= ok ? y_val : 16'd0;
			res_wheel_q  <= ok ? wheel_val : 8'd0;
			res_time_q   <= ts_s1;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.report_ok   = res_ok_q;
	assign result.button_bits = res_button_q;
	assign result.delta_x     = $signed(res_x_q);
	assign result.delta_y     = $signed(res_y_q);
	assign result.wheel_delta = $signed(res_wheel_q);
	assign result.motion_time = res_time_q;

endmodule

### design/mrp_checker.sv
module mrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_ok,
	input logic [15:0] res_button,
	input logic [15:0] res_x,
	input logic [15:0] res_y,
	input logic [7:0]  res_wheel,
	input logic [63:0] res_time
);

	// A result that is not taken stays and holds its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_button) &&
			$stable(res_x) && $stable(res_y) && $stable(res_wheel) && $stable(res_time))
	else $error("stalled result changed");

	// A failed report carries zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ok |-> res_button == 16'd0 && res_x == 16'd0 && res_y == 16'd0 &&
			res_wheel == 8'd0)
	else $error("failed report with nonzero fields");

	// With the result register empty the byte stream is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> in_ready)
	else $error("report stalled while no result is pending");

endmodule

bind mouse_report_parser mrp_checker u_mrp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (report.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_ok     (result.report_ok),
	.res_button (result.button_bits),
	.res_x      (result.delta_x),
	.res_y      (result.delta_y),
	.res_wheel  (result.wheel_delta),
	.res_time   (result.motion_time)
);

### bench/mouse_report_parser_tb.sv
`timescale 1ns / 100ps

module mouse_report_parser_tb;
	import mrp_pkg::*;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [2:0] REG_SPARE = 3'd7;
	// Cycles to let the block settle after the last result before a layout write.
	localparam int QUIET_CYCLES = 8;
	// Length of the long receiver hold-off in the backpressure test.
	localparam int HOLD_CYCLES = 150;

	// One parsed motion result as it should leave the block.
	typedef struct packed {
		logic               ok;
		logic [15:0]        buttons;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [7:0]  wheel;
		logic [63:0]        stamp;
	} motion_t;

	logic clk;
	logic arst_n;

	mrp_report_if rpt_ch ();
	mrp_result_if res_ch ();
	mrp_cfg_if    cfg_ch ();

	mouse_report_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (rpt_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Layout as the parser should currently see it, plus the per-report state.
	layout_t     lay;
	logic [7:0]  pos_cnt;
	logic [15:0] btn_acc;
	logic [15:0] x_acc;
	logic [15:0] y_acc;
	logic [7:0]  wheel_byte;
	logic        wheel_hit;
	logic        id_ok;

	motion_t expected_motion[$];
	motion_t head_motion;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_left;
	int fails;
	int bytes_sent;
	int results_seen;
	int parsed_seen;
	int layouts_used;
	int input_stalls;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [15:0] place_byte(logic [15:0] acc, int idx, logic [7:0] b);
		return (idx == 0) ? {acc[15:8], b} : {b, acc[7:0]};
	endfunction

	function automatic logic [15:0] widen_axis(logic [15:0] acc, int al);
		return (al == 1) ? {{8{acc[7]}}, acc[7:0]} : acc;
	endfunction

	function automatic layout_t make_layout(logic [7:0] id, logic [7:0] boff, logic [1:0] bbytes,
			logic [7:0] aoff, logic [1:0] abytes, logic [7:0] woff, logic wsigned);
		layout_t l;
		l.report_id_expected  = id;
		l.button_field_offset = boff;
		l.button_field_bytes  = bbytes;
		l.axis_field_offset   = aoff;
		l.axis_bytes_each     = abytes;
		l.wheel_field_offset  = woff;
		l.wheel_is_signed     = wsigned;
		return l;
	endfunction

	// Clear the per-report state after a last byte.
	task automatic clear_report();
		pos_cnt    = '0;
		btn_acc    = '0;
		x_acc      = '0;
		y_acc      = '0;
		wheel_byte = '0;
		wheel_hit  = 1'b0;
		id_ok      = 1'b0;
	endtask

	// Place one accepted byte into the report and queue a result on the last byte.
	task automatic parse_byte(input logic [7:0] b, input logic eor, input logic [63:0] stamp);
		int p;
		int bl;
		int al;
		int rel;
		int len;
		logic [7:0] w;
		motion_t m;
		p  = pos_cnt;
		bl = (lay.button_field_bytes > 2'd2) ? 2 : int'(lay.button_field_bytes);
		al = (lay.axis_bytes_each == 2'd1) ? 1 : 2;

		if (p == 0)
			id_ok = (lay.report_id_expected == 8'd0) || (b == lay.report_id_expected);

		rel = p - int'(lay.button_field_offset);
		if (rel >= 0 && rel < bl)
			btn_acc = place_byte(btn_acc, rel, b);

		// Y follows X directly.
		rel = p - int'(lay.axis_field_offset);
		if (rel >= 0 && rel < al)
			x_acc = place_byte(x_acc, rel, b);
		else if (rel >= al && rel < 2 * al)
			y_acc = place_byte(y_acc, rel - al, b);

		if (lay.wheel_field_offset != NO_WHEEL && p == int'(lay.wheel_field_offset)) begin
			wheel_byte = b;
			wheel_hit  = 1'b1;
		end

		// The position saturates, so every byte past the end lands on the last slot.
		if (p < int'(POS_MAX))
			pos_cnt = pos_cnt + 8'd1;

		if (eor) begin
			len  = p + 1;
			m.ok = id_ok && len >= int'(lay.axis_field_offset) + 2 * al
				&& len >= int'(lay.button_field_offset) + bl;
			w = 8'd0;
			if (lay.wheel_field_offset != NO_WHEEL && wheel_hit)
				w = lay.wheel_is_signed ? wheel_byte : (wheel_byte & WHEEL_LOW_MASK);
			m.buttons = m.ok ? btn_acc : 16'd0;
			m.dx      = m.ok ? widen_axis(x_acc, al) : 16'd0;
			m.dy      = m.ok ? widen_axis(y_acc, al) : 16'd0;
			m.wheel   = m.ok ? w : 8'd0;
			m.stamp   = stamp;
			expected_motion.push_back(m);
			clear_report();
		end
	endtask

	// Offer one byte, with a random gap first, and wait for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic eor, input logic [63:0] stamp);
		if ($urandom_range(99) < send_idle_pct) begin
			rpt_ch.valid         <= 1'b0;
			rpt_ch.report_byte   <= 8'($urandom);
			rpt_ch.end_of_report <= 1'($urandom);
			rpt_ch.time_stamp    <= {$urandom, $urandom};
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		rpt_ch.valid         <= 1'b1;
		rpt_ch.report_byte   <= b;
		rpt_ch.end_of_report <= eor;
		rpt_ch.time_stamp    <= stamp;
		do @(posedge clk); while (!rpt_ch.ready);
		bytes_sent++;
		parse_byte(b, eor, stamp);
	endtask

	task automatic send_report(input logic [7:0] data[$], input logic [63:0] stamp);
		foreach (data[i]) begin
			if (i == data.size() - 1)
				send_byte(data[i], 1'b1, stamp);
			else
				send_byte(data[i], 1'b0, {$urandom, $urandom});
		end
	endtask

	// Let every pending result drain and the pipeline settle.
	task automatic wait_quiet();
		rpt_ch.valid <= 1'b0;
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.reg_index  <= idx;
		cfg_ch.write_data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_REPORT_ID:    lay.report_id_expected  = data;
			REG_BTN_OFFSET:   lay.button_field_offset = data;
			REG_BTN_BYTES:    lay.button_field_bytes  = data[1:0];
			REG_AXIS_OFFSET:  lay.axis_field_offset   = data;
			REG_AXIS_BYTES:   lay.axis_bytes_each     = data[1:0];
			REG_WHEEL_OFFSET: lay.wheel_field_offset  = data;
			REG_WHEEL_SIGNED: lay.wheel_is_signed     = data[0];
			default: ;
		endcase
	endtask

	// Write a whole layout while the parser is idle; unused upper bits carry noise.
	task automatic set_layout(input layout_t l);
		wait_quiet();
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, 8'($urandom));
		write_reg(REG_REPORT_ID, l.report_id_expected);
		write_reg(REG_BTN_OFFSET, l.button_field_offset);
		write_reg(REG_BTN_BYTES, {6'($urandom), l.button_field_bytes});
		write_reg(REG_AXIS_OFFSET, l.axis_field_offset);
		write_reg(REG_AXIS_BYTES, {6'($urandom), l.axis_bytes_each});
		write_reg(REG_WHEEL_OFFSET, l.wheel_field_offset);
		write_reg(REG_WHEEL_SIGNED, {7'($urandom), l.wheel_is_signed});
		cfg_ch.valid <= 1'b0;
		layouts_used++;
	endtask

	function automatic layout_t random_layout();
		layout_t l;
		l.report_id_expected  = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(1, 255));
		l.button_field_offset = 8'($urandom_range(0, 4));
		l.button_field_bytes  = 2'($urandom_range(0, 3));
		l.axis_field_offset   = 8'($urandom_range(0, 6));
		if ($urandom_range(9) < 8)
			l.axis_bytes_each = 2'($urandom_range(1, 2));
		else
			l.axis_bytes_each = ($urandom_range(1) == 0) ? 2'd0 : 2'd3;
		l.wheel_field_offset  = ($urandom_range(1) == 0) ? NO_WHEEL : 8'($urandom_range(0, 10));
		l.wheel_is_signed     = 1'($urandom);
		return l;
	endfunction

	// Mostly complete reports with the right ID, some short or with a wrong ID.
	task automatic send_random_report();
		int need;
		int n;
		int bl;
		int al;
		int pick;
		logic [7:0] pkt[$];
		bl   = (lay.button_field_bytes > 2'd2) ? 2 : int'(lay.button_field_bytes);
		al   = (lay.axis_bytes_each == 2'd1) ? 1 : 2;
		need = int'(lay.axis_field_offset) + 2 * al;
		if (int'(lay.button_field_offset) + bl > need)
			need = int'(lay.button_field_offset) + bl;
		if (lay.wheel_field_offset != NO_WHEEL && int'(lay.wheel_field_offset) + 1 > need
				&& $urandom_range(99) < 80)
			need = int'(lay.wheel_field_offset) + 1;
		pick = $urandom_range(99);
		if (pick < 70)
			n = need + $urandom_range(0, 2);
		else if (pick < 85)
			n = $urandom_range(1, need);
		else
			n = $urandom_range(1, need + 4);
		repeat (n) pkt.push_back(8'($urandom));
		if (lay.report_id_expected != 8'd0 && $urandom_range(99) < 85)
			pkt[0] = lay.report_id_expected;
		send_report(pkt, {$urandom, $urandom});
	endtask

	// Default layout straight out of reset, with field extremes.
	task automatic test_reset_layout();
		logic [7:0] pkt[$];
		pkt = '{8'h00, 8'h00, 8'h00};
		send_report(pkt, 64'h0);
		pkt = '{8'hFF, 8'hFF, 8'hFF};
		send_report(pkt, 64'hFFFF_FFFF_FFFF_FFFF);
		pkt = '{8'h7F};
		send_report(pkt, 64'h8000_0000_0000_0001);
		pkt = '{8'h80, 8'h7F, 8'h80, 8'h55};
		send_report(pkt, 64'h0123_4567_89AB_CDEF);
	endtask

	// Report ID check, two-byte buttons and 16-bit axes with a signed wheel.
	task automatic test_id_and_wide_fields();
		logic [7:0] pkt[$];
		set_layout(make_layout(8'hFF, 8'd1, 2'd2, 8'd3, 2'd2, 8'd7, 1'b1));
		pkt = '{8'hFF, 8'h34, 8'h12, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h81};
		send_report(pkt, 64'h1);
		pkt[0] = 8'hFE;
		send_report(pkt, 64'h2);
	endtask

	// Unsigned wheel, a wheel past the end, and out-of-range field widths.
	task automatic test_wheel_and_widths();
		logic [7:0] pkt[$];
		set_layout(make_layout(8'd0, 8'd0, 2'd0, 8'd0, 2'd3, 8'd4, 1'b0));
		pkt = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hFF};
		send_report(pkt, 64'h3);
		set_layout(make_layout(8'd0, 8'd0, 2'd1, 8'd0, 2'd1, 8'd9, 1'b1));
		pkt = '{8'h11, 8'h22, 8'h33, 8'h44};
		send_report(pkt, 64'h4);
		set_layout(make_layout(8'd0, 8'd0, 2'd3, 8'd2, 2'd0, 8'd0, 1'b1));
		pkt = '{8'hAA, 8'h55, 8'h01, 8'h02, 8'h03, 8'h04};
		send_report(pkt, 64'h5);
	endtask

	// Reports longer than the position counter; the last byte wins the top slot.
	task automatic test_long_report();
		logic [7:0] pkt[$];
		set_layout(make_layout(8'd0, 8'd255, 2'd1, 8'd1, 2'd1, 8'd254, 1'b0));
		repeat (260) pkt.push_back(8'($urandom));
		send_report(pkt, {$urandom, $urandom});
		set_layout(make_layout(8'd0, 8'd0, 2'd2, 8'd255, 2'd2, NO_WHEEL, 1'b1));
		pkt.delete();
		repeat (257) pkt.push_back(8'($urandom));
		send_report(pkt, {$urandom, $urandom});
	endtask

	// Hold the result side off for a long stretch while bytes keep coming.
	task automatic test_backpressure();
		set_layout(make_layout(8'd0, 8'd0, 2'd1, 8'd1, 2'd1, NO_WHEEL, 1'b1));
		hold_req = HOLD_CYCLES;
		repeat (30) send_random_report();
	endtask

	task automatic run_random_phase(input int s_pct, input int r_pct, input int budget);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			set_layout(random_layout());
			repeat ($urandom_range(3, 8)) send_random_report();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Result side ready, with random stalls and the long hold-off.
	initial begin
		res_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every result transfer with the oldest expected motion.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rpt_ch.valid && !rpt_ch.ready)
				input_stalls++;
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (res_ch.report_ok === 1'b1)
					parsed_seen++;
				if (expected_motion.size() == 0) begin
					$error("unexpected result: report_ok %0b, motion_time %0h",
						res_ch.report_ok, res_ch.motion_time);
					fails++;
				end else begin
					head_motion = expected_motion.pop_front();
					check_field("report_ok", head_motion.ok, res_ch.report_ok);
					check_field("button_bits", head_motion.buttons, res_ch.button_bits);
					check_field("delta_x", head_motion.dx, res_ch.delta_x);
					check_field("delta_y", head_motion.dy, res_ch.delta_y);
					check_field("wheel_delta", head_motion.wheel, res_ch.wheel_delta);
					check_field("motion_time", head_motion.stamp, res_ch.motion_time);
				end
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n               = 1'b0;
		rpt_ch.valid         = 1'b0;
		rpt_ch.report_byte   = 8'd0;
		rpt_ch.end_of_report = 1'b0;
		rpt_ch.time_stamp    = 64'd0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.reg_index     = REG_REPORT_ID;
		cfg_ch.write_data    = 8'd0;
		lay = make_layout(8'd0, 8'd0, 2'd1, 8'd1, 2'd1, NO_WHEEL, 1'b1);
		clear_report();
		fails        = 0;
		bytes_sent   = 0;
		results_seen = 0;
		parsed_seen  = 0;
		layouts_used = 0;
		input_stalls = 0;
		hold_req     = 0;
		send_idle_pct = 38;
		recv_idle_pct = 69;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_layout();
		test_id_and_wide_fields();
		test_wheel_and_widths();
		test_long_report();
		run_random_phase(38, 69, 230);
		run_random_phase(69, 38, 230);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		run_random_phase(0, 0, 230);

		wait_quiet();
		$display("tb: sent %0d report bytes over %0d layouts; input stalled for %0d cycles",
			bytes_sent, layouts_used, input_stalls);
		$display("tb: checked %0d results, %0d parsed and %0d rejected",
			results_seen, parsed_seen, results_seen - parsed_seen);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
